### rtl/smma_pkg.sv
// Shared constants, types and helper functions for the load sample smoother.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package smma_pkg;

	localparam int MAX_WINDOW   = 16;
	localparam int SAMPLE_W     = 16;
	localparam int PTR_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int COUNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W        = SAMPLE_W + PTR_W;
	localparam int WIN_W        = 5;
	localparam int ALPHA_W      = 17;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 17;
	localparam int DIV_CNT_W    = $clog2(SUM_W);
	localparam int MAC_STEPS    = ALPHA_W;
	localparam int MAC_CNT_W    = $clog2(MAC_STEPS);
	localparam int ROUND_STEP   = SAMPLE_W - 1;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = ALPHA_W'(65536);
	localparam logic [ALPHA_W-1:0] ALPHA_DEFAULT = ALPHA_W'(19661);
	localparam logic [WIN_W-1:0]   WINDOW_RESET  = WIN_W'(5);

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_EXP_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MA_UPD,
		S_MA_DIV,
		S_EMA_MUL,
		S_RESULT
	} state_t;

	// Zero behaves as a window of one; anything above the ring depth saturates.
	function automatic logic [COUNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
		logic [COUNT_W-1:0] r;
		if (w == '0)
			r = COUNT_W'(1);
		else if (32'(w) > MAX_WINDOW)
			r = COUNT_W'(MAX_WINDOW);
		else
			r = COUNT_W'(w);
		return r;
	endfunction

	// Out-of-range weights fall back to the default of about 0.3.
	function automatic logic [ALPHA_W-1:0] eff_alpha(input logic [ALPHA_W-1:0] a);
		logic [ALPHA_W-1:0] r;
		if (a == '0 || a > ALPHA_ONE)
			r = ALPHA_DEFAULT;
		else
			r = a;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/smma_if.sv
// Handshake interfaces for the smoother: sample input, result output, register writes.
// Depends on smma_pkg for payload widths.
`default_nettype none

interface smma_in_if;
	logic                              valid;
	logic                              ready;
	logic [smma_pkg::SAMPLE_W-1:0]     sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface smma_out_if;
	logic                              valid;
	logic                              ready;
	logic [smma_pkg::SAMPLE_W-1:0]     smoothed;
	logic [smma_pkg::WIN_W-1:0]        history_count;

	modport source (output valid, output smoothed, output history_count, input ready);
	modport sink   (input valid, input smoothed, input history_count, output ready);
endinterface

interface smma_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [smma_pkg::CFG_IDX_W-1:0]    index;
	logic [smma_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/smma_serial_div.sv
// Bit-serial restoring divider: running sum over fill count, one quotient bit a cycle.
// Depends on smma_pkg for widths.
`default_nettype none

module smma_serial_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [smma_pkg::SUM_W-1:0]      dividend,
	input  wire logic [smma_pkg::COUNT_W-1:0]    divisor,
	output logic                                 done,
	output logic [smma_pkg::SAMPLE_W-1:0]        quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [smma_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [smma_pkg::COUNT_W-1:0]     div_q;
	logic [smma_pkg::COUNT_W-1:0]     rem_q;
	logic [smma_pkg::SUM_W-1:0]       quo_q;
	logic [smma_pkg::COUNT_W:0]       trial;
	logic                             fits;
	logic                             last_step;

	assign trial     = {rem_q, quo_q[smma_pkg::SUM_W-1]};
	assign fits      = trial >= {1'b0, div_q};
	assign last_step = cnt_q == smma_pkg::DIV_CNT_W'(smma_pkg::SUM_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract when the divisor fits
			rem_q <= fits ? smma_pkg::COUNT_W'(trial - {1'b0, div_q})
			              : smma_pkg::COUNT_W'(trial);
			quo_q <= {quo_q[smma_pkg::SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[smma_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

### rtl/smma_serial_mac.sv
// Bit-serial weighted blend alpha*x + (1-alpha)*s, rounded to nearest, weight in Q1.16.
// Depends on smma_pkg for widths and the weight constants.
`default_nettype none

module smma_serial_mac (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [smma_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic [smma_pkg::SAMPLE_W-1:0]   prev,
	input  wire logic [smma_pkg::ALPHA_W-1:0]    alpha,
	output logic                                 done,
	output logic [smma_pkg::SAMPLE_W-1:0]        result
);

	logic                             busy_q;
	logic                             done_q;
	logic [smma_pkg::MAC_CNT_W-1:0]   cnt_q;
	logic [smma_pkg::ALPHA_W-1:0]     a_sh_q;
	logic [smma_pkg::ALPHA_W-1:0]     b_sh_q;
	logic [smma_pkg::SAMPLE_W-1:0]    x_q;
	logic [smma_pkg::SAMPLE_W-1:0]    s_q;
	logic [smma_pkg::ALPHA_W-1:0]     acc_hi_q;
	logic [smma_pkg::ALPHA_W-1:0]     acc_lo_q;
	logic [smma_pkg::ALPHA_W-1:0]     a_eff;
	logic [smma_pkg::ALPHA_W:0]       addend;
	logic [smma_pkg::ALPHA_W:0]       sum;
	logic                             last_step;

	assign a_eff     = smma_pkg::eff_alpha(alpha);
	assign last_step = cnt_q == smma_pkg::MAC_CNT_W'(smma_pkg::MAC_STEPS - 1);

	// LSB-first: the rounding half enters as a carry at the step whose weight is 2^15
	assign addend = (a_sh_q[0] ? (smma_pkg::ALPHA_W + 1)'(x_q) : '0)
	              + (b_sh_q[0] ? (smma_pkg::ALPHA_W + 1)'(s_q) : '0)
	              + ((cnt_q == smma_pkg::MAC_CNT_W'(smma_pkg::ROUND_STEP))
	                 ? (smma_pkg::ALPHA_W + 1)'(1) : '0);
	assign sum    = {1'b0, acc_hi_q} + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q   <= a_eff;
			b_sh_q   <= smma_pkg::ALPHA_ONE - a_eff;
			x_q      <= sample;
			s_q      <= prev;
			acc_hi_q <= '0;
			acc_lo_q <= '0;
		end else if (busy_q) begin
			a_sh_q   <= a_sh_q >> 1;
			b_sh_q   <= b_sh_q >> 1;
			acc_hi_q <= sum[smma_pkg::ALPHA_W:1];
			acc_lo_q <= {sum[0], acc_lo_q[smma_pkg::ALPHA_W-1:1]};
		end
	end

	assign done   = done_q;
	// drop the 16 fraction bits of the product
	assign result = {acc_hi_q[smma_pkg::SAMPLE_W-2:0], acc_lo_q[smma_pkg::ALPHA_W-1]};

endmodule

`default_nettype wire

### rtl/sample_smoother_ma_ema_core.sv
// Load sample smoother, top level: moving average over a ring of recent samples or
// exponential smoothing, one result per sample. Takes one sample at a time; in
// moving-average mode a sample passes the update state and the bit-serial divider
// (one quotient bit per cycle over the 20-bit running sum) to the result register;
// in exponential mode it passes the bit-serial blend (17 weight bits), and the first
// sample only seeds the value and goes straight to the result state. The next sample is
// taken as soon as the result is in the output register, even if it is not yet drained.
// Any write to a defined register clears the window, sum, fill count and smoothed value.
// Depends on smma_pkg, smma_if, smma_serial_div and smma_serial_mac.
`default_nettype none

module sample_smoother_ma_ema_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	smma_in_if.sink      samples,
	smma_out_if.source   results,
	smma_cfg_if.sink     cfg
);

	smma_pkg::state_t                    state_q, state_next;

	logic                                exp_mode_q;
	logic [smma_pkg::WIN_W-1:0]          window_q;
	logic [smma_pkg::ALPHA_W-1:0]        alpha_q;

	logic [smma_pkg::SAMPLE_W-1:0]       ring_mem [smma_pkg::MAX_WINDOW];
	logic [smma_pkg::SAMPLE_W-1:0]       rd_data_q;
	logic [smma_pkg::PTR_W-1:0]          wp_q;
	logic [smma_pkg::PTR_W-1:0]          ptr_q;
	logic [smma_pkg::COUNT_W-1:0]        fill_q;
	logic [smma_pkg::SUM_W-1:0]          sum_q;
	logic [smma_pkg::SAMPLE_W-1:0]       ema_q;
	logic                                seeded_q;
	logic [smma_pkg::SAMPLE_W-1:0]       sample_q;
	logic [smma_pkg::SAMPLE_W-1:0]       res_q;

	logic                                out_valid_q;
	logic [smma_pkg::SAMPLE_W-1:0]       out_smoothed_q;
	logic [smma_pkg::COUNT_W-1:0]        out_count_q;

	logic                                in_accept;
	logic                                cfg_write;
	logic                                cfg_clear;
	logic [smma_pkg::COUNT_W-1:0]        win_eff;
	logic [smma_pkg::PTR_W-1:0]          ptr_cur;
	logic                                window_full;
	logic [smma_pkg::COUNT_W-1:0]        ptr_inc;
	logic [smma_pkg::SUM_W-1:0]          sum_next;
	logic [smma_pkg::COUNT_W-1:0]        fill_next;

	logic                                in_ready;
	logic                                seed_now;
	logic                                mac_start;
	logic                                ma_update;
	logic                                out_load;

	logic                                div_done;
	logic [smma_pkg::SAMPLE_W-1:0]       div_quot;
	logic                                mac_done;
	logic [smma_pkg::SAMPLE_W-1:0]       mac_res;

	assign in_accept = samples.valid && in_ready;
	assign cfg_write = cfg.valid;
	assign cfg_clear = cfg_write && (cfg.index == smma_pkg::REG_EXP_MODE
	                              || cfg.index == smma_pkg::REG_WINDOW
	                              || cfg.index == smma_pkg::REG_ALPHA);

	assign win_eff     = smma_pkg::eff_window(window_q);
	assign ptr_cur     = (smma_pkg::COUNT_W'(wp_q) >= win_eff) ? '0 : wp_q;
	assign window_full = fill_q >= win_eff;
	assign ptr_inc     = smma_pkg::COUNT_W'(ptr_q) + smma_pkg::COUNT_W'(1);
	// oldest sample leaves the sum once the window is full
	assign sum_next    = sum_q - (window_full ? smma_pkg::SUM_W'(rd_data_q) : '0)
	                   + smma_pkg::SUM_W'(sample_q);
	assign fill_next   = window_full ? fill_q : fill_q + 1'b1;

	// ---- next state ----
	always_comb begin
		state_next = state_q;
		case (state_q)
			smma_pkg::S_IDLE: begin
				if (in_accept) begin
					if (!exp_mode_q)
						state_next = smma_pkg::S_MA_UPD;
					else if (!seeded_q)
						state_next = smma_pkg::S_RESULT;
					else
						state_next = smma_pkg::S_EMA_MUL;
				end
			end
			smma_pkg::S_MA_UPD:  state_next = smma_pkg::S_MA_DIV;
			smma_pkg::S_MA_DIV: begin
				if (div_done)
					state_next = smma_pkg::S_RESULT;
			end
			smma_pkg::S_EMA_MUL: begin
				if (mac_done)
					state_next = smma_pkg::S_RESULT;
			end
			smma_pkg::S_RESULT: begin
				if (!out_valid_q || results.ready)
					state_next = smma_pkg::S_IDLE;
			end
			default: state_next = smma_pkg::S_IDLE;
		endcase
	end

	// ---- state outputs ----
	always_comb begin
		in_ready  = 1'b0;
		seed_now  = 1'b0;
		mac_start = 1'b0;
		ma_update = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			smma_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				seed_now  = in_accept && exp_mode_q && !seeded_q;
				mac_start = in_accept && exp_mode_q && seeded_q;
			end
			smma_pkg::S_MA_UPD: ma_update = 1'b1;
			smma_pkg::S_RESULT: out_load  = !out_valid_q || results.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= smma_pkg::S_IDLE;
		else
			state_q <= state_next;
	end

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_mode_q <= 1'b0;
			window_q   <= smma_pkg::WINDOW_RESET;
			alpha_q    <= smma_pkg::ALPHA_DEFAULT;
		end else if (cfg_write) begin
			case (cfg.index)
				smma_pkg::REG_EXP_MODE: exp_mode_q <= cfg.data[0];
				smma_pkg::REG_WINDOW:   window_q   <= cfg.data[smma_pkg::WIN_W-1:0];
				smma_pkg::REG_ALPHA:    alpha_q    <= cfg.data[smma_pkg::ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- smoothing state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			ema_q    <= '0;
			seeded_q <= 1'b0;
		end else if (cfg_clear) begin
			wp_q     <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			ema_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			if (ma_update) begin
				sum_q  <= sum_next;
				fill_q <= fill_next;
				wp_q   <= (ptr_inc >= win_eff) ? '0 : ptr_inc[smma_pkg::PTR_W-1:0];
			end
			if (seed_now) begin
				ema_q    <= samples.sample;
				seeded_q <= 1'b1;
			end
			if (mac_done)
				ema_q <= mac_res;
		end
	end

	// ---- work registers ----
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= samples.sample;
			ptr_q    <= ptr_cur;
		end
		if (seed_now)
			res_q <= samples.sample;
		if (div_done)
			res_q <= div_quot;
		if (mac_done)
			res_q <= mac_res;
	end

	// ---- history ring ----
	always_ff @(posedge clk) begin
		if (in_accept)
			rd_data_q <= ring_mem[ptr_cur];
		if (ma_update)
			ring_mem[ptr_q] <= sample_q;
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_smoothed_q <= res_q;
			out_count_q    <= fill_q;
		end
	end

	smma_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ma_update),
		.dividend (sum_next),
		.divisor  (fill_next),
		.done     (div_done),
		.quotient (div_quot)
	);

	smma_serial_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.sample (samples.sample),
		.prev   (ema_q),
		.alpha  (alpha_q),
		.done   (mac_done),
		.result (mac_res)
	);

	assign samples.ready         = in_ready;
	assign cfg.ready             = 1'b1;
	assign results.valid         = out_valid_q;
	assign results.smoothed      = out_smoothed_q;
	assign results.history_count = smma_pkg::WIN_W'(out_count_q);

endmodule

`default_nettype wire

### rtl/smma_checker.sv
// Port-level checker for the load sample smoother, bound to the top level.
// Depends on smma_pkg and sample_smoother_ma_ema_core.
`default_nettype none

module smma_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [smma_pkg::SAMPLE_W-1:0]     out_smoothed,
	input wire logic [smma_pkg::WIN_W-1:0]        out_count
);

	// the window never reports more samples than the ring holds
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_count) <= smma_pkg::MAX_WINDOW))
		else $error("history count beyond ring depth");

	// one sample in flight: no transaction right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after an accepted sample");

	// a result only appears after work on a sample, with the input closed just before
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work on a sample");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_smoothed)
		                               && $stable(out_count)))
		else $error("stalled result changed");

endmodule

bind sample_smoother_ma_ema_core smma_checker u_smma_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_smoothed (results.smoothed),
	.out_count    (results.history_count)
);

`default_nettype wire

### sim/tb_sample_smoother_ma_ema_core.sv
// Testbench for sample_smoother_ma_ema_core: directed and random load samples, with the
// registers rewritten between phases; every result is checked against an in-bench predictor.
// Depends on smma_pkg, the smma interfaces (smma_if.sv) and the smoother RTL.

module tb_sample_smoother_ma_ema_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 5;
	localparam int RANDOM_ITEMS    = 400;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IDLE_LIMIT      = 3000;
	localparam int DRAIN_CYCLES    = 40;

	typedef logic [smma_pkg::SAMPLE_W-1:0]   sample_t;
	typedef logic [smma_pkg::WIN_W-1:0]      count_t;
	typedef logic [smma_pkg::CFG_IDX_W-1:0]  reg_idx_t;
	typedef logic [smma_pkg::CFG_DATA_W-1:0] reg_data_t;

	// Index beyond the register list: the block must ignore it
	localparam reg_idx_t REG_SPARE = 3;

	typedef struct packed {
		sample_t smoothed;
		count_t  history_count;
	} smooth_out_t;

	typedef enum int {
		SPREAD_FULL,
		SPREAD_EDGES,
		SPREAD_HIGH,
		SPREAD_LOW
	} sample_spread_t;

	class smooth_scoreboard;
		bit                             ema_mode;
		logic [smma_pkg::WIN_W-1:0]     window_reg;
		logic [smma_pkg::ALPHA_W-1:0]   alpha_reg;
		sample_t                        ring [smma_pkg::MAX_WINDOW];
		int unsigned                    ring_ptr;
		int unsigned                    filled;
		logic [smma_pkg::SUM_W-1:0]     window_sum;
		sample_t                        ema_level;
		bit                             ema_started;
		smooth_out_t                    pending_outputs [$];
		int unsigned                    mismatches;

		function new();
			ema_mode   = 1'b0;
			window_reg = smma_pkg::WINDOW_RESET;
			alpha_reg  = smma_pkg::ALPHA_DEFAULT;
			mismatches = 0;
			clear_history();
		endfunction

		function void clear_history();
			foreach (ring[i])
				ring[i] = '0;
			ring_ptr    = 0;
			filled      = 0;
			window_sum  = '0;
			ema_level   = '0;
			ema_started = 1'b0;
		endfunction

		function int unsigned pending();
			return pending_outputs.size();
		endfunction

		function void apply_reg(reg_idx_t idx, reg_data_t data);
			case (idx)
				smma_pkg::REG_EXP_MODE: ema_mode = data[0];
				smma_pkg::REG_WINDOW:   window_reg = data[smma_pkg::WIN_W-1:0];
				smma_pkg::REG_ALPHA:    alpha_reg = data[smma_pkg::ALPHA_W-1:0];
				default:                return;
			endcase
			clear_history();
		endfunction

		function void note_sample(sample_t x);
			smooth_out_t                  r;
			int unsigned                  span;
			int unsigned                  p;
			logic [smma_pkg::ALPHA_W-1:0] a;
			logic [35:0]                  blend;
			if (ema_mode) begin
				if (!ema_started) begin
					ema_level   = x;
					ema_started = 1'b1;
				end else begin
					a = (alpha_reg == '0 || alpha_reg > smma_pkg::ALPHA_ONE)
						? smma_pkg::ALPHA_DEFAULT : alpha_reg;
					blend = 36'(a) * 36'(x) + 36'(smma_pkg::ALPHA_ONE - a) * 36'(ema_level)
						+ 36'd32768;
					ema_level = blend[31:16];
				end
				r.smoothed = ema_level;
			end else begin
				if (window_reg == '0)
					span = 1;
				else if (int'(window_reg) > smma_pkg::MAX_WINDOW)
					span = smma_pkg::MAX_WINDOW;
				else
					span = window_reg;
				p = (ring_ptr >= span) ? 0 : ring_ptr;
				// evict the oldest sample once the window is full
				if (filled >= span)
					window_sum -= ring[p];
				else
					filled++;
				ring[p]    = x;
				window_sum += x;
				ring_ptr   = (p + 1 >= span) ? 0 : p + 1;
				r.smoothed = sample_t'(window_sum / filled);
			end
			r.history_count = count_t'(filled);
			pending_outputs.insert(pending_outputs.size(), r);
		endfunction

		function void check_result(sample_t smoothed, count_t history_count);
			smooth_out_t want;
			if (pending_outputs.size() == 0) begin
				$error("unexpected result: smoothed=%0d history_count=%0d",
					smoothed, history_count);
				mismatches++;
				return;
			end
			want = pending_outputs[0];
			pending_outputs.delete(0);
			if (smoothed !== want.smoothed) begin
				$error("smoothed: expected %0d, got %0d", want.smoothed, smoothed);
				mismatches++;
			end
			if (history_count !== want.history_count) begin
				$error("history_count: expected %0d, got %0d",
					want.history_count, history_count);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned idle_cycles = 0;

	smma_in_if  samples_if ();
	smma_out_if results_if ();
	smma_cfg_if cfg_if ();

	sample_smoother_ma_ema_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	smooth_scoreboard board = new();

	always #CLK_HALF clk = ~clk;

	// Give up if no channel moves a transaction for too long
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** sample_smoother_ma_ema_core: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sample_t pick_sample(input sample_spread_t spread);
		case (spread)
			SPREAD_EDGES: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return '1;
					2:       return sample_t'(1);
					default: return sample_t'($urandom());
				endcase
			end
			SPREAD_HIGH: return sample_t'($urandom_range(16'hFF00, 16'hFFFF));
			SPREAD_LOW:  return sample_t'($urandom_range(0, 255));
			default:     return sample_t'($urandom());
		endcase
	endfunction

	function automatic reg_data_t pick_reg_value(input reg_idx_t idx);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (idx)
			smma_pkg::REG_EXP_MODE: begin
				if (roll < 80)
					return reg_data_t'($urandom_range(0, 1));
				return reg_data_t'($urandom());
			end
			smma_pkg::REG_WINDOW: begin
				if (roll < 60)
					return reg_data_t'($urandom_range(1, smma_pkg::MAX_WINDOW));
				if (roll < 85)
					return reg_data_t'($urandom_range(0, 31));
				return reg_data_t'($urandom());
			end
			smma_pkg::REG_ALPHA: begin
				if (roll < 50)
					return reg_data_t'($urandom_range(1, 65536));
				if (roll < 75) begin
					case ($urandom_range(0, 5))
						0:       return '0;
						1:       return reg_data_t'(1);
						2:       return reg_data_t'(65535);
						3:       return reg_data_t'(smma_pkg::ALPHA_ONE);
						4:       return reg_data_t'(65537);
						default: return '1;
					endcase
				end
				return reg_data_t'($urandom());
			end
			default: return reg_data_t'($urandom());
		endcase
	endfunction

	// Offer one sample; keep valid high afterwards when no gap follows
	task automatic send_sample(input sample_t x, input bit steady);
		int unsigned gap;
		samples_if.valid  <= 1'b1;
		samples_if.sample <= x;
		do @(posedge clk); while (!samples_if.ready);
		board.note_sample(x);
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold valid across back-to-back writes; drop it after the last one
	task automatic program_reg(input reg_idx_t idx, input reg_data_t data, input bit last);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		board.apply_reg(idx, data);
		if (last)
			cfg_if.valid <= 1'b0;
	endtask

	// Stop offering samples and wait for every outstanding result
	task automatic settle();
		samples_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic shuffle_config(input int unsigned round);
		int unsigned writes;
		reg_idx_t    idx;
		case (round)
			0: begin
				program_reg(smma_pkg::REG_EXP_MODE, '0, 1'b0);
				program_reg(smma_pkg::REG_WINDOW, reg_data_t'(smma_pkg::MAX_WINDOW), 1'b1);
			end
			1: begin
				program_reg(smma_pkg::REG_WINDOW, reg_data_t'(1), 1'b1);
			end
			2: begin
				program_reg(smma_pkg::REG_EXP_MODE, reg_data_t'(1), 1'b0);
				program_reg(smma_pkg::REG_ALPHA, reg_data_t'(1), 1'b1);
			end
			3: begin
				program_reg(smma_pkg::REG_ALPHA, reg_data_t'(smma_pkg::ALPHA_ONE), 1'b1);
			end
			default: begin
				writes = $urandom_range(1, 3);
				for (int unsigned k = 0; k < writes; k++) begin
					idx = ($urandom_range(0, 9) == 0) ? REG_SPARE
						: reg_idx_t'($urandom_range(0, 2));
					program_reg(idx, pick_reg_value(idx), k == writes - 1);
				end
			end
		endcase
	endtask

	task automatic run_burst(input int unsigned count, input sample_spread_t spread);
		bit steady;
		steady = ($urandom_range(0, 3) == 0);
		for (int unsigned i = 0; i < count; i++)
			send_sample(pick_sample(spread), steady);
	endtask

	// Result side: random stalls, steady stretches and one long hold-off
	initial begin
		int unsigned stall_left;
		int unsigned results_seen;
		bit          steady;
		bit          held_off;
		stall_left       = 0;
		results_seen     = 0;
		steady           = 1'b0;
		held_off         = 1'b0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_if.valid && results_if.ready) begin
				board.check_result(results_if.smoothed, results_if.history_count);
				results_seen++;
			end
			if (!held_off && results_seen >= 80 && samples_if.valid) begin
				held_off   = 1'b1;
				stall_left = HOLD_OFF_CYCLES;
			end
			if ($urandom_range(0, 199) == 0)
				steady = ~steady;
			if (stall_left != 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else if (steady || $urandom_range(0, 99) < 70) begin
				results_if.ready <= 1'b1;
			end else begin
				stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
					: $urandom_range(10, 60);
				results_if.ready <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned sent;
		int unsigned round;
		int unsigned count;
		arst_n            <= 1'b0;
		samples_if.valid  <= 1'b0;
		samples_if.sample <= '0;
		cfg_if.valid      <= 1'b0;
		cfg_if.index      <= '0;
		cfg_if.data       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Window of five after reset: fill, evict the zero, wrap round
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h8000, 1'b0);

		// Oversized window saturates to the ring depth
		settle();
		program_reg(smma_pkg::REG_WINDOW, reg_data_t'(31), 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);

		// Zero window behaves as one
		settle();
		program_reg(smma_pkg::REG_WINDOW, '0, 1'b1);
		send_sample(16'hABCD, 1'b0);
		send_sample(16'h1234, 1'b0);

		// Exponential mode with the reset weight: seed, then blend
		settle();
		program_reg(smma_pkg::REG_EXP_MODE, reg_data_t'(1), 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);

		// Full weight tracks the input
		settle();
		program_reg(smma_pkg::REG_ALPHA, reg_data_t'(smma_pkg::ALPHA_ONE), 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h5A5A, 1'b0);

		// Smallest weight: rounding lifts the value by one
		settle();
		program_reg(smma_pkg::REG_ALPHA, reg_data_t'(1), 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);

		// Zero and oversized weights fall back to the default
		settle();
		program_reg(smma_pkg::REG_ALPHA, '0, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		settle();
		program_reg(smma_pkg::REG_ALPHA, '1, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);

		// Undefined index leaves the smoothed value alone
		settle();
		program_reg(REG_SPARE, '1, 1'b1);
		send_sample(16'h8000, 1'b0);

		// Only bit 0 of the mode write counts
		settle();
		program_reg(smma_pkg::REG_EXP_MODE, reg_data_t'(17'h1FFFE), 1'b1);
		send_sample(16'h7FFF, 1'b0);

		sent  = 0;
		round = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			shuffle_config(round);
			count = ($urandom_range(0, 7) == 0) ? $urandom_range(35, 60)
				: $urandom_range(4, 24);
			run_burst(count, sample_spread_t'($urandom_range(0, 3)));
			sent += count;
			round++;
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("** sample_smoother_ma_ema_core: PASSED **");
		else
			$display("** sample_smoother_ma_ema_core: FAILED **");
		$finish;
	end

endmodule
